// ----- rtl/dcp_pkg.sv -----
// Shared widths, limits and handshake structs for the divisor count and
// perfect number test. No dependencies; every other file imports this.
package dcp_pkg;

  localparam int NUMBER_WIDTH = 16;
  localparam int NUM_FIELD_W  = 16;
  localparam int COUNT_W      = 16;
  localparam int SUM_W        = 20;
  localparam int REM_CNT_W    = $clog2(NUMBER_WIDTH + 1);
  localparam int ADD_W        = ((NUMBER_WIDTH > SUM_W) ? NUMBER_WIDTH : SUM_W) + 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};

  typedef logic [NUMBER_WIDTH-1:0] num_t;

  typedef struct packed {
    logic start;
    num_t dividend;
    num_t divisor;
  } rem_req_t;

  typedef struct packed {
    logic done;
    num_t rem;
  } rem_rsp_t;

  typedef struct packed {
    logic clear;
    logic update;
    logic in_sum;
    num_t trial;
  } acc_ctrl_t;

endpackage

// ----- rtl/dcp_ifs.sv -----
// Valid/ready channel interfaces for the number beat and the result beat.
// Depends on dcp_pkg for the field widths.
interface dcp_in_if import dcp_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [NUM_FIELD_W-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink (input valid, input number, output ready);
endinterface

interface dcp_out_if import dcp_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] divisor_count;
  logic [SUM_W-1:0]   proper_divisor_sum;
  logic               is_perfect;

  modport source (output valid, output divisor_count, output proper_divisor_sum,
                  output is_perfect, input ready);
  modport sink (input valid, input divisor_count, input proper_divisor_sum,
                input is_perfect, output ready);
endinterface

// ----- rtl/dcp_rem_unit.sv -----
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on dcp_pkg for the request and response structs.
module dcp_rem_unit import dcp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  rem_req_t req,
  output rem_rsp_t rsp
);

  logic                  busy_r;
  logic                  done_r;
  logic [REM_CNT_W-1:0]  cnt_r;
  num_t                  sr_r;
  num_t                  div_r;
  num_t                  rem_r;
  logic [NUMBER_WIDTH:0] trial;
  logic [NUMBER_WIDTH:0] diff;
  num_t                  rem_nxt;

  always_comb begin
    trial = {rem_r, sr_r[NUMBER_WIDTH-1]};
    diff  = trial - {1'b0, div_r};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = diff[NUMBER_WIDTH-1:0];
    end else begin
      rem_nxt = trial[NUMBER_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= REM_CNT_W'(NUMBER_WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - REM_CNT_W'(1);
        if (cnt_r == REM_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      sr_r  <= req.dividend;
      div_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      sr_r  <= {sr_r[NUMBER_WIDTH-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

// ----- rtl/dcp_accum.sv -----
// Divisor count and saturating proper divisor sum accumulators.
// Depends on dcp_pkg for widths, limits and the control struct.
module dcp_accum import dcp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  acc_ctrl_t          ctrl,
  output logic [COUNT_W-1:0] count,
  output logic [SUM_W-1:0]   sum
);

  logic [COUNT_W-1:0] count_r;
  logic [SUM_W-1:0]   sum_r;
  logic [ADD_W-1:0]   sum_ext;

  assign sum_ext = ADD_W'(sum_r) + ADD_W'(ctrl.trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
    end else if (ctrl.clear) begin
      count_r <= '0;
      sum_r   <= '0;
    end else if (ctrl.update) begin
      if (count_r != COUNT_MAX) begin
        count_r <= count_r + COUNT_W'(1);
      end
      if (ctrl.in_sum) begin
        if (sum_ext >= ADD_W'(SUM_MAX)) begin
          sum_r <= SUM_MAX;
        end else begin
          sum_r <= sum_ext[SUM_W-1:0];
        end
      end
    end
  end

  assign count = count_r;
  assign sum   = sum_r;

endmodule

// ----- rtl/divisor_count_and_perfect_test.sv -----
// Top level of the divisor count and perfect number test.
// Depends on dcp_pkg, dcp_ifs, dcp_rem_unit and dcp_accum.
//
//   channel  direction  fields
//   in_ch    sink       number
//   out_ch   source     divisor_count, proper_divisor_sum, is_perfect
//
// For a number n, every trial divisor from 1 to n runs through the shared
// bit-serial remainder unit once; a zero number goes straight to the finish
// state. Reset clears the sequencer and the accumulators.
// The next number is taken while a result still waits in the output register;
// a finished item waits only if that register is still full.
module divisor_count_and_perfect_test import dcp_pkg::*;
(
  input logic clk,
  input logic rst_n,
  dcp_in_if.sink    in_ch,
  dcp_out_if.source out_ch
);

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_FINISH} state_t;

  state_t             state_r;
  num_t               n_r;
  num_t               trial_r;
  logic               out_valid_r;
  logic [COUNT_W-1:0] out_count_r;
  logic [SUM_W-1:0]   out_sum_r;
  logic               out_perfect_r;

  num_t               n_in;
  logic               accept;
  logic               divides;
  logic               finish_take;
  rem_req_t           rem_req;
  rem_rsp_t           rem_rsp;
  acc_ctrl_t          acc_ctrl;
  logic [COUNT_W-1:0] acc_count;
  logic [SUM_W-1:0]   acc_sum;

  generate
    if (NUMBER_WIDTH <= NUM_FIELD_W) begin : g_narrow
      assign n_in = in_ch.number[NUMBER_WIDTH-1:0];
    end else begin : g_wide
      assign n_in = {{(NUMBER_WIDTH - NUM_FIELD_W){1'b0}}, in_ch.number};
    end
  endgenerate

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign divides     = (state_r == S_WAIT) && rem_rsp.done && (rem_rsp.rem == '0);
  assign finish_take = (state_r == S_FINISH) && (!out_valid_r || out_ch.ready);

  assign rem_req.start    = (state_r == S_ISSUE);
  assign rem_req.dividend = n_r;
  assign rem_req.divisor  = trial_r;

  assign acc_ctrl.clear  = accept;
  assign acc_ctrl.update = divides;
  assign acc_ctrl.in_sum = (trial_r <= (n_r >> 1));
  assign acc_ctrl.trial  = trial_r;

  dcp_rem_unit u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  dcp_accum u_acc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (acc_ctrl),
    .count (acc_count),
    .sum   (acc_sum)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (finish_take) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            n_r     <= n_in;
            trial_r <= num_t'(1);
            if (n_in == '0) begin
              state_r <= S_FINISH;
            end else begin
              state_r <= S_ISSUE;
            end
          end
        end
        S_ISSUE: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (rem_rsp.done) begin
            if (trial_r == n_r) begin
              state_r <= S_FINISH;
            end else begin
              trial_r <= trial_r + num_t'(1);
              state_r <= S_ISSUE;
            end
          end
        end
        S_FINISH: begin
          if (finish_take) begin
            out_count_r   <= acc_count;
            out_sum_r     <= acc_sum;
            out_perfect_r <= (n_r != '0) && (ADD_W'(acc_sum) == ADD_W'(n_r));
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.divisor_count      = out_count_r;
  assign out_ch.proper_divisor_sum = out_sum_r;
  assign out_ch.is_perfect         = out_perfect_r;

endmodule

// ----- rtl/dcp_checker.sv -----
// Port-level checks for the divisor count and perfect number test, bound to
// the top level. Depends on dcp_pkg for the field widths.
module dcp_checker import dcp_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [COUNT_W-1:0]     out_divisor_count,
  input logic [SUM_W-1:0]       out_proper_divisor_sum,
  input logic                   out_is_perfect
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result beat dropped before it was taken.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("A second number was taken while one was still being analysed.");

  a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_divisor_count == '0) |->
      (out_proper_divisor_sum == '0) && !out_is_perfect)
    else $error("A number with no divisors reported a sum or a perfect flag.");

  a_perfect_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_perfect |->
      (out_divisor_count > COUNT_W'(2)) && (out_proper_divisor_sum != '0))
    else $error("A perfect number was flagged with too few divisors.");

endmodule

bind divisor_count_and_perfect_test dcp_checker u_dcp_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .in_valid               (in_ch.valid),
  .in_ready               (in_ch.ready),
  .out_valid              (out_ch.valid),
  .out_ready              (out_ch.ready),
  .out_divisor_count      (out_ch.divisor_count),
  .out_proper_divisor_sum (out_ch.proper_divisor_sum),
  .out_is_perfect         (out_ch.is_perfect)
);

// ----- test/tb.sv -----
// Self-checking testbench for divisor_count_and_perfect_test: sends numbers on the input
// channel and checks each result beat against a trial-division predictor. Depends on
// dcp_pkg, the dcp_in_if/dcp_out_if interfaces and the RTL of the block.
module tb import dcp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [NUM_FIELD_W-1:0] number;
    logic [COUNT_W-1:0]     divisor_count;
    logic [SUM_W-1:0]       divisor_sum;
    logic                   perfect;
  } analysis_t;

  logic clk = 1'b0;
  logic rst_n;
  int   error_count = 0;
  int   cycle_count = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;

  analysis_t pending_analyses[$];

  dcp_in_if  in_ch();
  dcp_out_if out_ch();

  divisor_count_and_perfect_test dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #10ns clk = ~clk;

  function automatic analysis_t analyse_number(logic [NUM_FIELD_W-1:0] value);
    longint unsigned n;
    longint unsigned half;
    longint unsigned i;
    longint unsigned count;
    longint unsigned total;
    analysis_t       a;
    n     = longint'(value) & ((64'd1 << NUMBER_WIDTH) - 64'd1);
    half  = n / 2;
    count = 0;
    total = 0;
    for (i = 1; i <= n; i++) begin
      if (n % i == 0) begin
        if (count < COUNT_MAX) count++;
        if (i <= half) begin
          if (i >= SUM_MAX - total) total = SUM_MAX;
          else total += i;
        end
      end
    end
    a.number        = value;
    a.divisor_count = count[COUNT_W-1:0];
    a.divisor_sum   = total[SUM_W-1:0];
    a.perfect       = (n != 0) && (total == n);
    return a;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("divisor_count_and_perfect_test verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    analysis_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_analyses.size() == 0) begin
        $display("%0t: unexpected result beat count %0d sum %0d perfect %0d", $time,
                 out_ch.divisor_count, out_ch.proper_divisor_sum, out_ch.is_perfect);
        error_count++;
      end else begin
        want = pending_analyses.pop_front();
        if (out_ch.divisor_count !== want.divisor_count) begin
          $display("%0t: n=%0d divisor_count expected %0d actual %0d", $time,
                   want.number, want.divisor_count, out_ch.divisor_count);
          error_count++;
        end
        if (out_ch.proper_divisor_sum !== want.divisor_sum) begin
          $display("%0t: n=%0d proper_divisor_sum expected %0d actual %0d", $time,
                   want.number, want.divisor_sum, out_ch.proper_divisor_sum);
          error_count++;
        end
        if (out_ch.is_perfect !== want.perfect) begin
          $display("%0t: n=%0d is_perfect expected %0d actual %0d", $time,
                   want.number, want.perfect, out_ch.is_perfect);
          error_count++;
        end
      end
    end
  end

  task automatic send_number(input logic [NUM_FIELD_W-1:0] value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.number <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_analyses.push_back(analyse_number(value));
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (pending_analyses.size() != 0) @(posedge clk);
  endtask

  task automatic test_small_edges();
    logic [NUM_FIELD_W-1:0] values[$] = '{0, 1, 2, 3, 4, 16};
    foreach (values[k]) send_number(values[k]);
  endtask

  task automatic test_perfect_numbers();
    logic [NUM_FIELD_W-1:0] values[$] = '{6, 28, 496, 8128, 27, 497};
    foreach (values[k]) send_number(values[k]);
  endtask

  task automatic test_primes_and_composites();
    logic [NUM_FIELD_W-1:0] values[$] = '{97, 251, 12, 720, 1024};
    foreach (values[k]) send_number(values[k]);
  endtask

  task automatic test_field_maximum();
    send_number({NUM_FIELD_W{1'b1}});
  endtask

  task automatic test_drain_pause();
    repeat (4) send_number(NUM_FIELD_W'($urandom_range(0, 60)));
    wait_for_results();
    repeat (4) send_number(NUM_FIELD_W'($urandom_range(0, 60)));
  endtask

  task automatic test_random_numbers(input int items, input int send_pct, input int recv_pct);
    logic [NUM_FIELD_W-1:0] value;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (items) begin
      case ($urandom_range(0, 9))
        0: value = NUM_FIELD_W'($urandom_range(301, 2000));
        1: begin
          case ($urandom_range(0, 4))
            0: value = 0;
            1: value = 1;
            2: value = 6;
            3: value = 28;
            default: value = 496;
          endcase
        end
        default: value = NUM_FIELD_W'($urandom_range(0, 300));
      endcase
      send_number(value);
    end
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.number <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_small_edges();
    test_perfect_numbers();
    test_primes_and_composites();
    test_field_maximum();
    test_drain_pause();
    test_random_numbers(25, 15, 54);
    test_random_numbers(25, 54, 15);
    test_random_numbers(25, 0, 0);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("divisor_count_and_perfect_test verification clean");
    end else begin
      $display("divisor_count_and_perfect_test verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/dcp_pkg.sv
rtl/dcp_ifs.sv
rtl/dcp_rem_unit.sv
rtl/dcp_accum.sv
rtl/divisor_count_and_perfect_test.sv
rtl/dcp_checker.sv
test/tb.sv
